[src/psfr_pkg.sv]
// ============================================================================
// psfr_pkg: shared definitions for the preamble sync frame receiver
// Holds the store geometry, the command and receive-mode codes, the
// configuration register indexes and the store write request type.
// ============================================================================
package psfr_pkg;

  // Frame store geometry: two banks of MAX_FRAME_BYTES bytes each.
  localparam int MAX_FRAME_BYTES = 16384;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
  localparam int STORE_AW        = ADDR_W + 1;
  localparam int STORE_DEPTH     = 2 * MAX_FRAME_BYTES;

  // Field widths fixed by the interface.
  localparam int BYTE_W      = 8;
  localparam int FRAME_LEN_W = 15;
  localparam int PREAMBLE_W  = 32;
  localparam int MATCH_W     = 2;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd1;

  // Reset value of the frame length register.
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = FRAME_LEN_W'(16384);

  // Input commands.
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TAKE = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  // Receive modes.
  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_DROP    = 2'd2
  } rx_mode_t;

  // One write into the frame store.
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   data;
  } store_wr_t;

endpackage

[src/psfr_store.sv]
// ============================================================================
// psfr_store: ping-pong frame store
// One write port and one read port with registered read data.
// ============================================================================
module psfr_store
  import psfr_pkg::*;
(
  input  logic                clk,
  input  store_wr_t           wr,
  input  logic                rd_en,
  input  logic [STORE_AW-1:0] rd_addr,
  output logic [BYTE_W-1:0]   rd_data
);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/psfr_rx_ctrl.sv]
// ============================================================================
// psfr_rx_ctrl: preamble hunt and frame capture control
// Tracks the preamble match, writes captured bytes into the receive bank,
// flags a finished frame and swaps banks on a take.
// ============================================================================
module psfr_rx_ctrl
  import psfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_en,
  input  logic [BYTE_W-1:0]      byte_data,
  input  logic                   byte_last,
  input  logic                   take_en,
  input  logic [PREAMBLE_W-1:0]  preamble,
  input  logic [FRAME_LEN_W-1:0] frame_len,
  output store_wr_t              wr,
  output logic                   rx_bank,
  output logic                   frame_taken
);

  localparam logic [FRAME_LEN_W-1:0] MAX_LEN = FRAME_LEN_W'(MAX_FRAME_BYTES);

  rx_mode_t               mode_r, mode_nxt;
  logic [MATCH_W-1:0]     match_r, match_nxt;
  logic [FRAME_LEN_W-1:0] offset_r, offset_nxt;
  logic                   ready_r, ready_nxt;
  logic                   bank_r, bank_nxt;

  logic [FRAME_LEN_W-1:0] eff_len;
  logic [FRAME_LEN_W-1:0] offset_inc;
  logic [BYTE_W-1:0]      want;

  // Effective frame length: zero acts as one, capped at the bank size.
  always_comb begin
    if (frame_len == '0) begin
      eff_len = FRAME_LEN_W'(1);
    end else if (frame_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = frame_len;
    end
  end

  assign offset_inc = offset_r + FRAME_LEN_W'(1);
  assign want       = preamble[BYTE_W*match_r +: BYTE_W];

  // Next state.
  always_comb begin
    mode_nxt   = mode_r;
    match_nxt  = match_r;
    offset_nxt = offset_r;
    ready_nxt  = ready_r;
    bank_nxt   = bank_r;
    if (byte_en) begin
      case (mode_r)
        MODE_CAPTURE: begin
          if (ready_r) begin
            // A frame is still waiting: drop the rest of this packet.
            if (byte_last) begin
              mode_nxt  = MODE_HUNT;
              match_nxt = '0;
            end else begin
              mode_nxt = MODE_DROP;
            end
          end else begin
            offset_nxt = offset_inc;
            if (offset_inc >= eff_len) begin
              ready_nxt = 1'b1;
              mode_nxt  = MODE_HUNT;
              match_nxt = '0;
            end
          end
        end
        MODE_DROP: begin
          if (byte_last) begin
            mode_nxt  = MODE_HUNT;
            match_nxt = '0;
          end
        end
        default: begin
          // Hunting; a failing byte is not rechecked as a first byte.
          if (byte_data == want) begin
            match_nxt = match_r + MATCH_W'(1);
            if (match_r == '1) begin
              mode_nxt   = MODE_CAPTURE;
              offset_nxt = '0;
            end
          end else begin
            match_nxt = '0;
          end
        end
      endcase
    end else if (take_en && ready_r) begin
      bank_nxt  = ~bank_r;
      ready_nxt = 1'b0;
    end
  end

  // Outputs: store write for captured bytes and the take result.
  always_comb begin
    wr.en       = byte_en && (mode_r == MODE_CAPTURE) && !ready_r &&
                  (offset_r < MAX_LEN);
    wr.addr     = {bank_r, offset_r[ADDR_W-1:0]};
    wr.data     = byte_data;
    rx_bank     = bank_r;
    frame_taken = ready_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_HUNT;
      match_r  <= '0;
      offset_r <= '0;
      ready_r  <= 1'b0;
      bank_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      match_r  <= match_nxt;
      offset_r <= offset_nxt;
      ready_r  <= ready_nxt;
      bank_r   <= bank_nxt;
    end
  end

endmodule

[src/preamble_sync_frame_receiver.sv]
// ============================================================================
// preamble_sync_frame_receiver: preamble-synchronized frame receiver
// Hunts a four-byte preamble in a byte stream and captures the following
// frame into a ping-pong store that the host takes and reads.
// ============================================================================
// Usage:
// The in_ channel carries one command per beat: a received byte (tlast marks
// the end of its packet), a take of a ready frame, or a read of one byte of
// the presented bank. Take and read each give one beat on the out_ channel;
// received bytes give none. The cfg_ channel writes the preamble word and the
// frame length and is always ready; write it only while the block is idle.
// One beat is accepted every cycle while in_tready is high. A result beat
// goes through the store read stage and then the output register before it
// is valid on the out_ channel: one stage for each of the two registers.
// While out_tready is low the output register and the
// read stage hold, and in_tready stays high until both are full; then it
// follows out_tready. Reset clears the receive state, both control stages
// and the registers (preamble 0, frame length 16384); the store contents are
// undefined until written, and a read is meant only after a successful take.
// ============================================================================
module preamble_sync_frame_receiver
  import psfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input beats.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,  // data_byte[7:0], read_address[21:8], zero
  input  logic [1:0]            in_tuser,  // command[1:0]
  input  logic                  in_tlast,
  // Result beats.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata, // frame_taken[0], read_data[8:1], zero
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PREAMBLE_W-1:0] cfg_data
);

  logic [PREAMBLE_W-1:0]  preamble_r;
  logic [FRAME_LEN_W-1:0] frame_len_r;

  logic                   accept;
  cmd_t                   cmd;
  logic                   byte_fire;
  logic                   take_fire;
  logic                   read_fire;

  store_wr_t              wr;
  logic                   rx_bank;
  logic                   frame_taken;
  logic [BYTE_W-1:0]      rd_data;
  logic [STORE_AW-1:0]    rd_addr;

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_read_r;
  logic                   s1_taken_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_taken_r;
  logic [BYTE_W-1:0]      out_data_r;
  logic                   out_free;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r  <= '0;
      frame_len_r <= FRAME_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PREAMBLE: preamble_r  <= cfg_data;
        CFG_LENGTH:   frame_len_r <= cfg_data[FRAME_LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // Command decode.
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign byte_fire = accept && (cmd == CMD_BYTE);
  assign take_fire = accept && (cmd == CMD_TAKE);
  assign read_fire = accept && (cmd == CMD_READ);

  psfr_rx_ctrl u_rx_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (byte_fire),
    .byte_data   (in_tdata[7:0]),
    .byte_last   (in_tlast),
    .take_en     (take_fire),
    .preamble    (preamble_r),
    .frame_len   (frame_len_r),
    .wr          (wr),
    .rx_bank     (rx_bank),
    .frame_taken (frame_taken)
  );

  // Reads go to the presented bank, the one not receiving.
  assign rd_addr = {~rx_bank, in_tdata[8 +: ADDR_W]};

  psfr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (read_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Flow control across the read stage and the output register.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = take_fire || read_fire;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage payload: kind of result and take outcome.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_r  <= read_fire;
      s1_taken_r <= take_fire && frame_taken;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_taken_r <= s1_taken_r;
      out_data_r  <= s1_read_r ? rd_data : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r, out_taken_r};

endmodule
